@@ src/rmq_pkg.sv @@
// Package for the rotation matrix to quaternion block.
// Word widths, derived arithmetic widths and the types shared by all modules.
// Depends on nothing.
package rmq_pkg;

   localparam int WORD_WIDTH = 16;
   localparam int FRAC_BITS  = WORD_WIDTH - 2;
   localparam int LANES      = 3;

   // Signed radicand: three words plus one, with headroom.
   localparam int RAD_WIDTH  = WORD_WIDTH + 3;
   // Square root operand: positive radicand shifted up by the fraction bits.
   localparam int SQIN_WIDTH = RAD_WIDTH - 1 + FRAC_BITS;
   localparam int ROOT_WIDTH = (SQIN_WIDTH + 1) / 2;
   // Off-diagonal sums and differences.
   localparam int DIFF_WIDTH = WORD_WIDTH + 1;
   // Dividend: magnitude shifted by FRAC_BITS+1, plus four times the half root.
   localparam int NUM_WIDTH  = DIFF_WIDTH + FRAC_BITS + 2;
   // Divisor is eight times the half root.
   localparam int DV_WIDTH   = ROOT_WIDTH + 3;
   // One quotient bit beyond the word flags an overflow.
   localparam int QUOT_WIDTH = WORD_WIDTH + 1;
   localparam int REM_WIDTH  = (NUM_WIDTH > DV_WIDTH + WORD_WIDTH) ?
                               NUM_WIDTH : DV_WIDTH + WORD_WIDTH;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic signed [DIFF_WIDTH-1:0] diff_type;

   typedef enum logic [1:0] {
      DOM_X = 2'd0,
      DOM_Y = 2'd1,
      DOM_Z = 2'd2,
      DOM_W = 2'd3
   } dom_type;

   typedef struct packed {
      dom_type                dom;
      logic                   degen;
      diff_type [LANES-1:0]   diff;
   } side_type;

   typedef struct packed {
      dom_type                dom;
      logic                   degen;
      logic [LANES-1:0]       neg;
      logic [ROOT_WIDTH-1:0]  half;
   } quot_info_type;

   typedef logic [LANES-1:0][QUOT_WIDTH-1:0] quot_vec_type;

endpackage

@@ src/rotation_matrix_to_quaternion_top.sv @@
// Rotation matrix (signed Q2.14) to unit quaternion (signed Q2.14), fully
// pipelined: one item enters per cycle unless stalled. It has one front stage,
// 16 square root stages, one rounding stage, 17 divider stages and the output
// register, the depth being set by the one-bit-per-stage square root and
// dividers. The trace branch is used for a non-negative trace, otherwise the
// branch of the largest diagonal entry; the dominant component is the rounded
// half root and the other three are divided by it, all saturated. A radicand
// of zero or below gives zero components with degenerate set. Each stage holds
// its item under stall, so an empty stage still takes the next item.
module rotation_matrix_to_quaternion_top
   import rmq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  word_type req_m00,
   input  word_type req_m01,
   input  word_type req_m02,
   input  word_type req_m10,
   input  word_type req_m11,
   input  word_type req_m12,
   input  word_type req_m20,
   input  word_type req_m21,
   input  word_type req_m22,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output word_type rsp_qx,
   output word_type rsp_qy,
   output word_type rsp_qz,
   output word_type rsp_qw,
   output logic     rsp_degenerate
);

   localparam word_type WORD_MAX = {1'b0, {(WORD_WIDTH - 1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_WIDTH - 1){1'b0}}};

   logic                  front_valid, front_stall;
   logic [SQIN_WIDTH-1:0] front_sqin;
   side_type              front_side;
   logic                  sqrt_valid, sqrt_stall;
   logic [ROOT_WIDTH-1:0] sqrt_root;
   side_type              sqrt_side;
   logic                  div_valid, div_stall;
   quot_vec_type          div_quot;
   quot_info_type         div_info;
   word_type              lane_word [LANES];
   word_type              dom_word;
   word_type              qx_in, qy_in, qz_in, qw_in;
   word_type              qx_ff, qy_ff, qz_ff, qw_ff;
   logic                  degen_ff, valid_ff, out_ready;

   function automatic word_type sat_quot(logic [QUOT_WIDTH-1:0] q, logic neg);
      logic [QUOT_WIDTH-1:0] lim;
      lim = QUOT_WIDTH'(1) << (WORD_WIDTH - 1);
      if (neg) begin
         return (q > lim) ? WORD_MIN : -q[WORD_WIDTH-1:0];
      end
      return (q >= lim) ? WORD_MAX : q[WORD_WIDTH-1:0];
   endfunction

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_m00    (req_m00),
      .in_m01    (req_m01),
      .in_m02    (req_m02),
      .in_m10    (req_m10),
      .in_m11    (req_m11),
      .in_m12    (req_m12),
      .in_m20    (req_m20),
      .in_m21    (req_m21),
      .in_m22    (req_m22),
      .out_valid (front_valid),
      .out_stall (front_stall),
      .out_sqin  (front_sqin),
      .out_side  (front_side)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_sqin   (front_sqin),
      .in_side   (front_side),
      .out_valid (sqrt_valid),
      .out_stall (sqrt_stall),
      .out_root  (sqrt_root),
      .out_side  (sqrt_side)
   );

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .in_stall  (sqrt_stall),
      .in_root   (sqrt_root),
      .in_side   (sqrt_side),
      .out_valid (div_valid),
      .out_stall (div_stall),
      .out_quot  (div_quot),
      .out_info  (div_info)
   );

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_word[l] = sat_quot(div_quot[l], div_info.neg[l]);
      end
      if (div_info.half >= (ROOT_WIDTH'(1) << (WORD_WIDTH - 1))) begin
         dom_word = WORD_MAX;
      end else begin
         dom_word = WORD_WIDTH'(div_info.half);
      end
      unique case (div_info.dom)
         DOM_W: begin
            qx_in = lane_word[0];
            qy_in = lane_word[1];
            qz_in = lane_word[2];
            qw_in = dom_word;
         end
         DOM_Z: begin
            qx_in = lane_word[0];
            qy_in = lane_word[1];
            qz_in = dom_word;
            qw_in = lane_word[2];
         end
         DOM_Y: begin
            qx_in = lane_word[0];
            qy_in = dom_word;
            qz_in = lane_word[1];
            qw_in = lane_word[2];
         end
         default: begin
            qx_in = dom_word;
            qy_in = lane_word[0];
            qz_in = lane_word[1];
            qw_in = lane_word[2];
         end
      endcase
      if (div_info.degen) begin
         qx_in = '0;
         qy_in = '0;
         qz_in = '0;
         qw_in = '0;
      end
   end

   assign out_ready = !valid_ff || !rsp_stall;
   assign div_stall = !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_ready) begin
         valid_ff <= div_valid;
      end
      if (out_ready && div_valid) begin
         qx_ff    <= qx_in;
         qy_ff    <= qy_in;
         qz_ff    <= qz_in;
         qw_ff    <= qw_in;
         degen_ff <= div_info.degen;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_qx         = qx_ff;
   assign rsp_qy         = qy_ff;
   assign rsp_qz         = qz_ff;
   assign rsp_qw         = qw_ff;
   assign rsp_degenerate = degen_ff;

endmodule

@@ src/rmq_front.sv @@
// Front stage: trace, branch selection, radicand and off-diagonal terms.
// Uses rmq_pkg for widths and the side-band type.
module rmq_front
   import rmq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  word_type              in_m00,
   input  word_type              in_m01,
   input  word_type              in_m02,
   input  word_type              in_m10,
   input  word_type              in_m11,
   input  word_type              in_m12,
   input  word_type              in_m20,
   input  word_type              in_m21,
   input  word_type              in_m22,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [SQIN_WIDTH-1:0] out_sqin,
   output side_type              out_side
);

   logic signed [RAD_WIDTH-1:0] e00, e11, e22, trace, one, rad;
   side_type                    side_in, side_ff;
   logic [SQIN_WIDTH-1:0]       sqin_in, sqin_ff;
   logic                        valid_ff, ready;

   function automatic diff_type add_w(word_type a, word_type b);
      return DIFF_WIDTH'(a) + DIFF_WIDTH'(b);
   endfunction

   function automatic diff_type sub_w(word_type a, word_type b);
      return DIFF_WIDTH'(a) - DIFF_WIDTH'(b);
   endfunction

   always_comb begin
      e00   = RAD_WIDTH'(in_m00);
      e11   = RAD_WIDTH'(in_m11);
      e22   = RAD_WIDTH'(in_m22);
      one   = RAD_WIDTH'(1) <<< FRAC_BITS;
      trace = e00 + e11 + e22;
      side_in.degen = 1'b0;
      if (trace >= 0) begin
         side_in.dom     = DOM_W;
         rad             = trace + one;
         side_in.diff[0] = sub_w(in_m21, in_m12);
         side_in.diff[1] = sub_w(in_m02, in_m20);
         side_in.diff[2] = sub_w(in_m10, in_m01);
      end else if ((in_m11 > in_m00 && in_m22 > in_m11) ||
                   (!(in_m11 > in_m00) && in_m22 > in_m00)) begin
         side_in.dom     = DOM_Z;
         rad             = e22 - e00 - e11 + one;
         side_in.diff[0] = add_w(in_m20, in_m02);
         side_in.diff[1] = add_w(in_m12, in_m21);
         side_in.diff[2] = sub_w(in_m10, in_m01);
      end else if (in_m11 > in_m00) begin
         side_in.dom     = DOM_Y;
         rad             = e11 - e22 - e00 + one;
         side_in.diff[0] = add_w(in_m01, in_m10);
         side_in.diff[1] = add_w(in_m12, in_m21);
         side_in.diff[2] = sub_w(in_m02, in_m20);
      end else begin
         side_in.dom     = DOM_X;
         rad             = e00 - e11 - e22 + one;
         side_in.diff[0] = add_w(in_m01, in_m10);
         side_in.diff[1] = add_w(in_m20, in_m02);
         side_in.diff[2] = sub_w(in_m21, in_m12);
      end
      // A radicand of zero or below goes through as zero and is masked at the end.
      if (rad[RAD_WIDTH-1] || rad == '0) begin
         side_in.degen = 1'b1;
         sqin_in       = '0;
      end else begin
         sqin_in = {rad[RAD_WIDTH-2:0], FRAC_BITS'(0)};
      end
   end

   assign ready = !valid_ff || !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
      if (ready && in_valid) begin
         side_ff <= side_in;
         sqin_ff <= sqin_in;
      end
   end

   assign in_stall  = !ready;
   assign out_valid = valid_ff;
   assign out_sqin  = sqin_ff;
   assign out_side  = side_ff;

endmodule

@@ src/rmq_sqrt.sv @@
// Pipelined floor square root, one result bit per register stage.
// Uses rmq_pkg for widths and the side-band type carried alongside.
module rmq_sqrt
   import rmq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic [SQIN_WIDTH-1:0] in_sqin,
   input  side_type              in_side,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [ROOT_WIDTH-1:0] out_root,
   output side_type              out_side
);

   localparam int STAGES      = ROOT_WIDTH;
   localparam int TRIAL_WIDTH = 2 * ROOT_WIDTH + 1;

   logic                  valid_ff [STAGES];
   logic [SQIN_WIDTH-1:0] rem_ff   [STAGES];
   logic [ROOT_WIDTH-1:0] root_ff  [STAGES];
   side_type              side_ff  [STAGES];
   logic                  src_valid[STAGES];
   logic [SQIN_WIDTH-1:0] src_rem  [STAGES];
   logic [ROOT_WIDTH-1:0] src_root [STAGES];
   side_type              src_side [STAGES];
   logic                  ready    [STAGES+1];

   assign ready[STAGES] = !out_stall;

   generate
      for (genvar k = 0; k < STAGES; k++) begin : g_stage
         localparam int BIT = STAGES - 1 - k;
         logic [TRIAL_WIDTH-1:0] rem_x, trial;
         logic [SQIN_WIDTH-1:0]  rem_in;
         logic [ROOT_WIDTH-1:0]  root_in;

         if (k == 0) begin : g_first
            assign src_valid[k] = in_valid;
            assign src_rem[k]   = in_sqin;
            assign src_root[k]  = '0;
            assign src_side[k]  = in_side;
         end else begin : g_next
            assign src_valid[k] = valid_ff[k-1];
            assign src_rem[k]   = rem_ff[k-1];
            assign src_root[k]  = root_ff[k-1];
            assign src_side[k]  = side_ff[k-1];
         end

         assign ready[k] = !valid_ff[k] || ready[k+1];

         // Setting bit BIT grows the square by root*2^(BIT+1) + 2^(2*BIT); the
         // two terms never overlap, so an OR forms the sum.
         always_comb begin
            rem_x = TRIAL_WIDTH'(src_rem[k]);
            trial = (TRIAL_WIDTH'(src_root[k]) << (BIT + 1)) |
                    (TRIAL_WIDTH'(1) << (2 * BIT));
            if (rem_x >= trial) begin
               rem_in  = SQIN_WIDTH'(rem_x - trial);
               root_in = src_root[k] | (ROOT_WIDTH'(1) << BIT);
            end else begin
               rem_in  = src_rem[k];
               root_in = src_root[k];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (ready[k]) begin
               valid_ff[k] <= src_valid[k];
            end
            if (ready[k] && src_valid[k]) begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
               side_ff[k] <= src_side[k];
            end
         end
      end
   endgenerate

   assign in_stall  = !ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

@@ src/rmq_div.sv @@
// Rounds the root to the dominant component and divides the three off-diagonal
// terms by it in three restoring divider lanes, one quotient bit per stage.
// Uses rmq_pkg for widths and the side-band types.
module rmq_div
   import rmq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic [ROOT_WIDTH-1:0] in_root,
   input  side_type              in_side,
   output logic                  out_valid,
   input  logic                  out_stall,
   output quot_vec_type          out_quot,
   output quot_info_type         out_info
);

   localparam int STAGES = QUOT_WIDTH;

   typedef logic [LANES-1:0][REM_WIDTH-1:0] rem_vec_type;

   // Preparation stage
   logic                  prep_valid_ff, prep_ready;
   rem_vec_type           prep_rem_in, prep_rem_ff;
   logic [DV_WIDTH-1:0]   prep_dv_in, prep_dv_ff;
   quot_info_type         prep_info_in, prep_info_ff;
   logic [ROOT_WIDTH:0]   root_inc;
   logic [DIFF_WIDTH-1:0] mag [LANES];

   // Divider stages
   logic                  valid_ff [STAGES];
   rem_vec_type           rem_ff   [STAGES];
   quot_vec_type          quot_ff  [STAGES];
   logic [DV_WIDTH-1:0]   dv_ff    [STAGES];
   quot_info_type         info_ff  [STAGES];
   logic                  src_valid[STAGES];
   rem_vec_type           src_rem  [STAGES];
   quot_vec_type          src_quot [STAGES];
   logic [DV_WIDTH-1:0]   src_dv   [STAGES];
   quot_info_type         src_info [STAGES];
   logic                  ready    [STAGES+1];

   always_comb begin
      // Half root, rounded to nearest with ties upward.
      root_inc               = {1'b0, in_root} + (ROOT_WIDTH + 1)'(1);
      prep_info_in.half      = root_inc[ROOT_WIDTH:1];
      prep_info_in.dom       = in_side.dom;
      prep_info_in.degen     = in_side.degen;
      prep_dv_in             = {prep_info_in.half, 3'b000};
      for (int l = 0; l < LANES; l++) begin
         prep_info_in.neg[l] = in_side.diff[l][DIFF_WIDTH-1];
         mag[l]              = prep_info_in.neg[l] ? -in_side.diff[l] : in_side.diff[l];
         // Adding half the divisor rounds the quotient to nearest.
         prep_rem_in[l]      = REM_WIDTH'((NUM_WIDTH'(mag[l]) << (FRAC_BITS + 1)) +
                                          (NUM_WIDTH'(prep_info_in.half) << 2));
      end
   end

   assign prep_ready = !prep_valid_ff || ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_ready) begin
         prep_valid_ff <= in_valid;
      end
      if (prep_ready && in_valid) begin
         prep_rem_ff  <= prep_rem_in;
         prep_dv_ff   <= prep_dv_in;
         prep_info_ff <= prep_info_in;
      end
   end

   assign ready[STAGES] = !out_stall;

   generate
      for (genvar k = 0; k < STAGES; k++) begin : g_stage
         localparam int BIT = STAGES - 1 - k;
         logic [REM_WIDTH-1:0] sub;
         rem_vec_type          rem_in;
         quot_vec_type         quot_in;

         if (k == 0) begin : g_first
            assign src_valid[k] = prep_valid_ff;
            assign src_rem[k]   = prep_rem_ff;
            assign src_quot[k]  = '0;
            assign src_dv[k]    = prep_dv_ff;
            assign src_info[k]  = prep_info_ff;
         end else begin : g_next
            assign src_valid[k] = valid_ff[k-1];
            assign src_rem[k]   = rem_ff[k-1];
            assign src_quot[k]  = quot_ff[k-1];
            assign src_dv[k]    = dv_ff[k-1];
            assign src_info[k]  = info_ff[k-1];
         end

         assign ready[k] = !valid_ff[k] || ready[k+1];

         // When the top bit is set the quotient is out of range and saturates,
         // so the lower bits need not be exact.
         always_comb begin
            sub = REM_WIDTH'(src_dv[k]) << BIT;
            for (int l = 0; l < LANES; l++) begin
               quot_in[l] = src_quot[k][l];
               if (src_rem[k][l] >= sub) begin
                  rem_in[l]       = src_rem[k][l] - sub;
                  quot_in[l][BIT] = 1'b1;
               end else begin
                  rem_in[l] = src_rem[k][l];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (ready[k]) begin
               valid_ff[k] <= src_valid[k];
            end
            if (ready[k] && src_valid[k]) begin
               rem_ff[k]  <= rem_in;
               quot_ff[k] <= quot_in;
               dv_ff[k]   <= src_dv[k];
               info_ff[k] <= src_info[k];
            end
         end
      end
   endgenerate

   assign in_stall  = !prep_ready;
   assign out_valid = valid_ff[STAGES-1];
   assign out_quot  = quot_ff[STAGES-1];
   assign out_info  = info_ff[STAGES-1];

endmodule
